[rtl/dmsc_pkg.sv]
// Shared types and constants for the dual motor slew command encoder.
// No dependencies; imported by dmsc_motor and the top level.
package dmsc_pkg;

  localparam int SPD_W  = 16;
  localparam int STEP_W = 15;
  localparam int BYTE_W = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPEED_FLOOR = 2'd0;
  localparam logic [1:0] CFG_SPEED_CEIL  = 2'd1;
  localparam logic [1:0] CFG_STEP_LIMIT  = 2'd2;

  // Driver opcodes
  localparam logic [BYTE_W-1:0] COAST_M0 = 8'h86;
  localparam logic [BYTE_W-1:0] COAST_M1 = 8'h87;
  localparam logic [BYTE_W-1:0] OPS_M0   = 8'h88;
  localparam logic [BYTE_W-1:0] OPS_M1   = 8'h8C;

  localparam logic [BYTE_W-1:0] MAG_CAP          = 8'd255;
  localparam logic [BYTE_W-1:0] SEVEN_BIT_MAX    = 8'd127;
  localparam logic [BYTE_W-1:0] EIGHT_BIT_OFFSET = 8'd128;

  localparam logic signed [SPD_W-1:0] SPD_MOST_NEG = 16'sh8000;
  localparam logic signed [SPD_W-1:0] SPD_MOST_POS = 16'sh7FFF;

  typedef struct packed {
    logic signed [SPD_W-1:0] target_left;
    logic signed [SPD_W-1:0] target_right;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
  } out_item_t;

  typedef struct packed {
    logic signed [SPD_W-1:0]  speed_floor;
    logic signed [SPD_W-1:0]  speed_ceil;
    logic        [STEP_W-1:0] step_limit;
  } cfg_t;

  // One motor's update: new speed and its command bytes
  typedef struct packed {
    logic signed [SPD_W-1:0] speed;
    logic [BYTE_W-1:0]       op;
    logic [BYTE_W-1:0]       data;
    logic                    two_bytes;
  } motor_cmd_t;

endpackage

[rtl/dmsc_motor.sv]
// Slew and command encode for one motor, purely combinational.
// Depends on dmsc_pkg.
module dmsc_motor (
  input  logic                             motor_id,
  input  dmsc_pkg::cfg_t                   cfg,
  input  logic signed [dmsc_pkg::SPD_W-1:0] speed_now,
  input  logic signed [dmsc_pkg::SPD_W-1:0] target_raw,
  output dmsc_pkg::motor_cmd_t             cmd
);
  import dmsc_pkg::*;

  logic signed [SPD_W-1:0]  tgt;
  logic                     in_window;
  logic signed [SPD_W:0]    diff;
  logic signed [SPD_W:0]    step_pos;
  logic signed [SPD_W:0]    step_neg;
  logic signed [SPD_W:0]    diff_clamped;
  logic signed [SPD_W:0]    sum;
  logic signed [SPD_W-1:0]  spd;
  logic        [SPD_W-1:0]  abs_spd;
  logic        [BYTE_W-1:0] mag;
  logic                     big;
  logic                     coast;

  always_comb begin
    // Negate, saturating the most negative input
    tgt = (target_raw == SPD_MOST_NEG) ? SPD_MOST_POS : -target_raw;
    in_window = (tgt >= cfg.speed_floor) && (tgt <= cfg.speed_ceil);

    diff     = {tgt[SPD_W-1], tgt} - {speed_now[SPD_W-1], speed_now};
    step_pos = {2'b00, cfg.step_limit};
    step_neg = -step_pos;
    if (diff > step_pos) begin
      diff_clamped = step_pos;
    end else if (diff < step_neg) begin
      diff_clamped = step_neg;
    end else begin
      diff_clamped = diff;
    end
    sum = {speed_now[SPD_W-1], speed_now} + diff_clamped;
    spd = in_window ? sum[SPD_W-1:0] : speed_now;

    abs_spd = spd[SPD_W-1] ? SPD_W'(-spd) : SPD_W'(spd);
    mag     = (abs_spd > SPD_W'(MAG_CAP)) ? MAG_CAP : abs_spd[BYTE_W-1:0];
    big     = mag > SEVEN_BIT_MAX;
    coast   = (spd == '0) && (tgt != '0);

    cmd.speed     = spd;
    cmd.two_bytes = !coast;
    if (coast) begin
      cmd.op   = motor_id ? COAST_M1 : COAST_M0;
      cmd.data = '0;
    end else begin
      cmd.op   = (motor_id ? OPS_M1 : OPS_M0) | {6'b0, spd[SPD_W-1], big};
      cmd.data = big ? (mag - EIGHT_BIT_OFFSET) : mag;
    end
  end

endmodule

[rtl/dual_motor_slew_command_encoder_top.sv]
// Top level of the dual motor slew command encoder.
// Depends on dmsc_pkg and dmsc_motor.
//
//   channel | ports                          | moves per transfer
//   --------+--------------------------------+------------------------------
//   in      | in_valid, in_stall, in_data    | two target speeds (one tick)
//   out     | out_valid, out_stall, out_data | one command byte + last flag
//   cfg     | cfg_we, cfg_index, cfg_wdata   | one register write
//
// Each tick yields two to four bytes, one byte per cycle on the output while
// out_stall is low; the single byte channel sets the pace of the ticks.
// A tick sits in the input register, is slewed and encoded in one pass and
// moves into the byte buffer as soon as the previous tick's last byte goes.
// Reset (rst_n low, synchronous) empties both stages, zeroes the speeds and
// loads floor -255, ceiling 255, step 10. A stalled output holds its byte.
module dual_motor_slew_command_encoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dmsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dmsc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import dmsc_pkg::*;

  // Configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_floor <= -16'sd255;
      cfg_r.speed_ceil  <= 16'sd255;
      cfg_r.step_limit  <= 15'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPEED_FLOOR: cfg_r.speed_floor <= cfg_wdata;
        CFG_SPEED_CEIL:  cfg_r.speed_ceil  <= cfg_wdata;
        CFG_STEP_LIMIT:  cfg_r.step_limit  <= cfg_wdata[STEP_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Input register stage
  logic     a_valid_r;
  in_item_t a_data_r;
  logic     in_xfer;
  logic     a_adv;

  // Byte buffer stage
  logic              b_valid_r;
  logic [BYTE_W-1:0] b_bytes_r [4];
  logic [1:0]        b_last_idx_r;
  logic [1:0]        b_idx_r;
  logic              out_xfer;
  logic              b_at_last;
  logic              b_free;

  // Present speeds
  logic signed [SPD_W-1:0] speed_left_r;
  logic signed [SPD_W-1:0] speed_right_r;

  motor_cmd_t cmd_left;
  motor_cmd_t cmd_right;

  logic [BYTE_W-1:0] bytes_nxt [4];
  logic [1:0]        last_idx_nxt;

  dmsc_motor u_motor_l (
    .motor_id   (1'b0),
    .cfg        (cfg_r),
    .speed_now  (speed_left_r),
    .target_raw (a_data_r.target_left),
    .cmd        (cmd_left)
  );

  dmsc_motor u_motor_r (
    .motor_id   (1'b1),
    .cfg        (cfg_r),
    .speed_now  (speed_right_r),
    .target_raw (a_data_r.target_right),
    .cmd        (cmd_right)
  );

  // Pack motor 0's bytes first, then motor 1's, into the four byte slots
  always_comb begin
    bytes_nxt[0] = cmd_left.op;
    if (cmd_left.two_bytes) begin
      bytes_nxt[1] = cmd_left.data;
      bytes_nxt[2] = cmd_right.op;
      bytes_nxt[3] = cmd_right.data;
    end else begin
      bytes_nxt[1] = cmd_right.op;
      bytes_nxt[2] = cmd_right.data;
      bytes_nxt[3] = cmd_right.data;
    end
    last_idx_nxt = 2'd1 + {1'b0, cmd_left.two_bytes} + {1'b0, cmd_right.two_bytes};
  end

  assign out_xfer  = b_valid_r && !out_stall;
  assign b_at_last = (b_idx_r == b_last_idx_r);
  assign b_free    = !b_valid_r || (out_xfer && b_at_last);
  assign a_adv     = a_valid_r && b_free;
  assign in_stall  = a_valid_r && !b_free;
  assign in_xfer   = in_valid && !in_stall;

  assign out_valid          = b_valid_r;
  assign out_data.out_byte  = b_bytes_r[b_idx_r];
  assign out_data.last_byte = b_at_last;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      b_valid_r     <= 1'b0;
      b_idx_r       <= '0;
      b_last_idx_r  <= '0;
      speed_left_r  <= '0;
      speed_right_r <= '0;
    end else begin
      if (in_xfer) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end

      if (a_adv) begin
        // Commit the tick: advance speeds and start its byte run
        b_valid_r     <= 1'b1;
        b_idx_r       <= '0;
        b_last_idx_r  <= last_idx_nxt;
        speed_left_r  <= cmd_left.speed;
        speed_right_r <= cmd_right.speed;
      end else if (out_xfer) begin
        if (b_at_last) begin
          b_valid_r <= 1'b0;
        end else begin
          b_idx_r <= b_idx_r + 2'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_data_r <= in_data;
    end
    if (a_adv) begin
      for (int i = 0; i < 4; i++) begin
        b_bytes_r[i] <= bytes_nxt[i];
      end
    end
  end

  // Every tick carries at least two bytes
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_last_idx_r != 2'd0))
    else $error("byte run shorter than two bytes");

  // The read pointer never passes the end of the run
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_idx_r <= b_last_idx_r))
    else $error("byte index beyond run");

  // A non-final byte transfer leaves the run in progress
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !b_at_last) |=> (b_valid_r && b_idx_r == $past(b_idx_r) + 2'd1))
    else $error("byte run broken early");

  // Speeds only change when a tick commits
  a_speed_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(a_adv) && $past(rst_n) |-> ($stable(speed_left_r) && $stable(speed_right_r)))
    else $error("speed changed without a tick");

  // Speeds never reach the most negative code
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (speed_left_r != SPD_MOST_NEG) && (speed_right_r != SPD_MOST_NEG))
    else $error("speed out of range");

endmodule
